>>> rtl/ebm_pkg.sv
// shared types and constants for the 3x3 box mean block
`timescale 1ns / 1ps
`default_nettype none
package ebm_pkg;

  localparam int PIX_W          = 8;
  localparam int COL_W          = 10;
  localparam int ROW_W          = 12;
  localparam int MEAN_W         = 16;
  localparam int CFG_WIDTH_W    = 11;
  localparam int CFG_HEIGHT_W   = 13;
  localparam int SUM_W          = 12;
  localparam int NUM_W          = 20;
  localparam int RCP_W          = 23;
  localparam int RCP_SH         = 24;
  localparam int QUO_W          = NUM_W + RCP_W - RCP_SH;
  localparam int APB_AW         = 3;
  localparam int APB_DW         = 32;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 4096;

  localparam logic [CFG_WIDTH_W-1:0]  RST_WIDTH  = CFG_WIDTH_W'(640);
  localparam logic [CFG_HEIGHT_W-1:0] RST_HEIGHT = CFG_HEIGHT_W'(480);

  localparam logic REG_IDX_WIDTH  = 1'b0;
  localparam logic REG_IDX_HEIGHT = 1'b1;

  localparam logic [RCP_W-1:0] RECIP3 = RCP_W'((64'd1 << RCP_SH) / 3);
  localparam logic [RCP_W-1:0] RECIP9 = RCP_W'((64'd1 << RCP_SH) / 9);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SLOT,
    ST_MUL,
    ST_FIX,
    ST_OUT
  } ebm_state_t;

  typedef enum logic [1:0] {
    DIV_BY4,
    DIV_BY6,
    DIV_BY9
  } ebm_div_t;

  typedef struct packed {
    logic rd;
    logic shift;
    logic calc;
    logic mul;
    logic fix;
  } ebm_cmd_t;

  typedef struct packed {
    logic pend;
  } ebm_sts_t;

endpackage
`default_nettype wire

>>> rtl/ebm_if.sv
// stream interfaces for the pixel input and the mean result channels
`timescale 1ns / 1ps
`default_nettype none
interface ebm_pix_if;
  logic                       valid;
  logic                       ready;
  logic [ebm_pkg::PIX_W-1:0]  pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface ebm_res_if;
  logic                        valid;
  logic                        ready;
  logic [ebm_pkg::COL_W-1:0]   col;
  logic [ebm_pkg::ROW_W-1:0]   row;
  logic [ebm_pkg::MEAN_W-1:0]  mean_q8;
  logic                        frame_end;

  modport source (output valid, output col, output row, output mean_q8, output frame_end,
                  input ready);
  modport sink   (input valid, input col, input row, input mean_q8, input frame_end,
                  output ready);
endinterface
`default_nettype wire

>>> rtl/ebm_regs.sv
// apb register file holding image width and height
`timescale 1ns / 1ps
`default_nettype none
module ebm_regs (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [ebm_pkg::APB_AW-1:0]         paddr,
  input  wire logic [ebm_pkg::APB_DW-1:0]         pwdata,
  output logic      [ebm_pkg::APB_DW-1:0]         prdata,
  output logic                                    pready,
  output logic      [ebm_pkg::CFG_WIDTH_W-1:0]    cfg_width,
  output logic      [ebm_pkg::CFG_HEIGHT_W-1:0]   cfg_height,
  output logic                                    cfg_wr
);
  import ebm_pkg::*;

  logic [CFG_WIDTH_W-1:0]  width_r, width_nxt;
  logic [CFG_HEIGHT_W-1:0] height_r, height_nxt;
  logic                    idx;

  assign idx    = paddr[2];
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_wr) begin
      if (idx == REG_IDX_WIDTH) begin
        width_nxt = pwdata[CFG_WIDTH_W-1:0];
      end else begin
        height_nxt = pwdata[CFG_HEIGHT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_WIDTH;
      height_r <= RST_HEIGHT;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  always_comb begin
    if (idx == REG_IDX_WIDTH) begin
      prdata = APB_DW'(width_r);
    end else begin
      prdata = APB_DW'(height_r);
    end
  end

  assign cfg_width  = width_r;
  assign cfg_height = height_r;
endmodule
`default_nettype wire

>>> rtl/ebm_ctrl.sv
// sequencer: accept, line store access, per-result divide steps, output handshake
`timescale 1ns / 1ps
`default_nettype none
module ebm_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire ebm_pkg::ebm_sts_t  sts,
  output ebm_pkg::ebm_cmd_t       cmd
);
  import ebm_pkg::*;

  ebm_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_LOAD;
      end
      ST_LOAD: state_nxt = ST_SLOT;
      ST_SLOT: begin
        state_nxt = sts.pend ? ST_MUL : ST_IDLE;
      end
      ST_MUL:  state_nxt = ST_FIX;
      ST_FIX:  state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_ready) state_nxt = sts.pend ? ST_SLOT : ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.rd   = in_valid;
      end
      ST_LOAD: cmd.shift = 1'b1;
      ST_SLOT: cmd.calc  = sts.pend;
      ST_MUL:  cmd.mul   = 1'b1;
      ST_FIX:  cmd.fix   = 1'b1;
      ST_OUT:  out_valid = 1'b1;
      default: cmd = '0;
    endcase
  end
endmodule
`default_nettype wire

>>> rtl/ebm_dp.sv
// datapath: line store, 3x3 window, position counters, masked sum and constant divide
`timescale 1ns / 1ps
`default_nettype none
module ebm_dp #(
  parameter int MAX_WIDTH  = ebm_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ebm_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire ebm_pkg::ebm_cmd_t                 cmd,
  output ebm_pkg::ebm_sts_t                      sts,
  input  wire logic                              cfg_wr,
  input  wire logic [ebm_pkg::CFG_WIDTH_W-1:0]   cfg_width,
  input  wire logic [ebm_pkg::CFG_HEIGHT_W-1:0]  cfg_height,
  input  wire logic [ebm_pkg::PIX_W-1:0]         pixel,
  output logic      [ebm_pkg::COL_W-1:0]         col,
  output logic      [ebm_pkg::ROW_W-1:0]         row,
  output logic      [ebm_pkg::MEAN_W-1:0]        mean_q8,
  output logic                                   frame_end
);
  import ebm_pkg::*;

  localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;

  // line store: upper row in the high byte, middle row in the low byte
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_q_r;
  logic [PIX_W-1:0]   pix_r;
  logic [PIX_W-1:0]   win_r [9];

  logic [CW-1:0] col_r, col_nxt, pc_r;
  logic [RW-1:0] row_r, row_nxt, pr_r;
  logic [3:0]    pend_r, pend_nxt;

  logic [31:0] w_ext, h_ext, wm1_full, hm1_full;
  logic [CW-1:0] wm1;
  logic [RW-1:0] hm1;

  // slot selection and masked sum
  logic [1:0]       slot;
  logic [CW-1:0]    cx;
  logic [RW-1:0]    cy;
  logic [1:0]       wc, wr;
  logic             top_ok, bot_ok, left_ok, right_ok;
  logic [2:0]       row_sel, col_sel;
  logic [SUM_W-1:0] sum;
  ebm_div_t         mode;

  logic [SUM_W-1:0] sum_r;
  ebm_div_t         mode_r;
  logic [CW-1:0]    cx_r;
  logic [RW-1:0]    cy_r;
  logic             fe_r;

  logic [NUM_W-1:0]       numer, numer_r;
  logic [RCP_W-1:0]       recip;
  logic [NUM_W+RCP_W-1:0] prod;
  logic [QUO_W-1:0]       q0_r;

  logic [NUM_W+1:0]  dq, rem;
  logic [QUO_W-1:0]  quo;
  logic [MEAN_W-1:0] mean;

  logic [COL_W-1:0]  col_o_r;
  logic [ROW_W-1:0]  row_o_r;
  logic [MEAN_W-1:0] mean_r;
  logic              fe_o_r;

  // effective size, clamped to the supported range
  assign w_ext = 32'(cfg_width);
  assign h_ext = 32'(cfg_height);
  assign wm1_full = (w_ext < 32'd2) ? 32'd1 :
                    (w_ext > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH - 1) : w_ext - 32'd1;
  assign hm1_full = (h_ext < 32'd2) ? 32'd1 :
                    (h_ext > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT - 1) : h_ext - 32'd1;
  assign wm1 = CW'(wm1_full);
  assign hm1 = RW'(hm1_full);

  // line store access
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_q_r <= line_mem[col_r];
      pix_r  <= pixel;
    end
    if (cmd.shift) begin
      line_mem[col_r] <= {rd_q_r[PIX_W-1:0], pix_r};
    end
  end

  // window shift
  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      for (int k = 0; k < 3; k++) begin
        win_r[k*3+0] <= win_r[k*3+1];
        win_r[k*3+1] <= win_r[k*3+2];
      end
      win_r[2] <= rd_q_r[2*PIX_W-1:PIX_W];
      win_r[5] <= rd_q_r[PIX_W-1:0];
      win_r[8] <= pix_r;
    end
  end

  // position counters and pending results of the current item
  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    pend_nxt = pend_r;
    if (cmd.shift) begin
      pend_nxt[0] = (row_r != '0) && (col_r != '0);
      pend_nxt[1] = (row_r != '0) && (col_r == wm1);
      pend_nxt[2] = (row_r == hm1) && (col_r != '0);
      pend_nxt[3] = (row_r == hm1) && (col_r == wm1);
      if (col_r == wm1) begin
        col_nxt = '0;
        row_nxt = (row_r == hm1) ? '0 : row_r + RW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
    if (cmd.calc) begin
      pend_nxt[slot] = 1'b0;
    end
    if (cfg_wr) begin
      col_nxt = '0;
      row_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      pend_r <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      pc_r <= col_r;
      pr_r <= row_r;
    end
  end

  assign sts.pend = |pend_r;

  // lowest pending slot: bit 0 picks the centre column, bit 1 the centre row
  always_comb begin
    if (pend_r[0]) begin
      slot = 2'd0;
    end else if (pend_r[1]) begin
      slot = 2'd1;
    end else if (pend_r[2]) begin
      slot = 2'd2;
    end else begin
      slot = 2'd3;
    end
  end

  always_comb begin
    cx       = slot[0] ? pc_r : pc_r - CW'(1);
    cy       = slot[1] ? pr_r : pr_r - RW'(1);
    wc       = slot[0] ? 2'd2 : 2'd1;
    wr       = slot[1] ? 2'd2 : 2'd1;
    top_ok   = (cy != '0);
    bot_ok   = (cy != hm1);
    left_ok  = (cx != '0);
    right_ok = (cx != wm1);
    for (int i = 0; i < 3; i++) begin
      row_sel[i] = (2'(i) == wr) || ((2'(i) + 2'd1 == wr) && top_ok) ||
                   ((2'(i) == wr + 2'd1) && bot_ok);
      col_sel[i] = (2'(i) == wc) || ((2'(i) + 2'd1 == wc) && left_ok) ||
                   ((2'(i) == wc + 2'd1) && right_ok);
    end
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (row_sel[i] && col_sel[j]) begin
          sum = sum + SUM_W'(win_r[i*3+j]);
        end
      end
    end
    if (top_ok && bot_ok && left_ok && right_ok) begin
      mode = DIV_BY9;
    end else if ((top_ok && bot_ok) || (left_ok && right_ok)) begin
      mode = DIV_BY6;
    end else begin
      mode = DIV_BY4;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      sum_r  <= sum;
      mode_r <= mode;
      cx_r   <= cx;
      cy_r   <= cy;
      fe_r   <= &slot;
    end
  end

  // reciprocal multiply, underestimates the quotient by at most one
  always_comb begin
    case (mode_r)
      DIV_BY9: begin
        numer = {sum_r, 8'd0};
        recip = RECIP9;
      end
      DIV_BY6: begin
        numer = NUM_W'({sum_r, 7'd0});
        recip = RECIP3;
      end
      default: begin
        numer = NUM_W'({sum_r, 6'd0});
        recip = RECIP3;
      end
    endcase
    prod = NUM_W'(numer) * (NUM_W+RCP_W)'(recip);
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      numer_r <= numer;
      q0_r    <= prod[NUM_W+RCP_W-1:RCP_SH];
    end
  end

  // one compare and subtract corrects the estimate
  always_comb begin
    if (mode_r == DIV_BY9) begin
      dq  = (NUM_W+2)'({q0_r, 3'd0}) + (NUM_W+2)'(q0_r);
      rem = (NUM_W+2)'(numer_r) - dq;
      quo = (rem >= (NUM_W+2)'(9)) ? q0_r + QUO_W'(1) : q0_r;
    end else begin
      dq  = (NUM_W+2)'({q0_r, 1'd0}) + (NUM_W+2)'(q0_r);
      rem = (NUM_W+2)'(numer_r) - dq;
      quo = (rem >= (NUM_W+2)'(3)) ? q0_r + QUO_W'(1) : q0_r;
    end
    case (mode_r)
      DIV_BY4:          mean = MEAN_W'({sum_r, 6'd0});
      DIV_BY6, DIV_BY9: mean = MEAN_W'(quo);
      default:          mean = MEAN_W'(quo);
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.fix) begin
      col_o_r <= COL_W'(cx_r);
      row_o_r <= ROW_W'(cy_r);
      mean_r  <= mean;
      fe_o_r  <= fe_r;
    end
  end

  assign col       = col_o_r;
  assign row       = row_o_r;
  assign mean_q8   = mean_r;
  assign frame_end = fe_o_r;
endmodule
`default_nettype wire

>>> rtl/edge_aware_box_mean_3x3.sv
// top level of the edge aware 3x3 box mean filter
//
// pixels enter in raster order on in_chan, one 8-bit blue value per item.
// each result item on out_chan carries the centre column and row, the mean
// of the in-image 3x3 neighbours as unsigned q8.8, and frame_end on the
// result for the last pixel of the frame. a centre leaves once its
// lower-right neighbour has arrived, so an item yields zero to four results.
// image width and height sit at byte addresses 0 and 4 of the apb port;
// any write restarts the frame at column 0, row 0.
// one item is worked at a time, and the results of an item come from one
// shared divide-by-constant unit (sum, reciprocal multiply, correction)
// that handles them one after another. a stalled receiver holds the result
// in the output register and the block takes no new item until it is taken.
// reset returns the frame position to the origin and the size registers to
// 640 x 480; the line store is not cleared, since only rows of the current
// frame are ever read from it.
`timescale 1ns / 1ps
`default_nettype none
module edge_aware_box_mean_3x3 #(
  parameter int MAX_WIDTH  = ebm_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ebm_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  ebm_pix_if.sink                          in_chan,
  ebm_res_if.source                        out_chan,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [ebm_pkg::APB_AW-1:0]  paddr,
  input  wire logic [ebm_pkg::APB_DW-1:0]  pwdata,
  output logic      [ebm_pkg::APB_DW-1:0]  prdata,
  output logic                             pready
);
  import ebm_pkg::*;

  ebm_cmd_t                cmd;
  ebm_sts_t                sts;
  logic                    cfg_wr;
  logic [CFG_WIDTH_W-1:0]  cfg_width;
  logic [CFG_HEIGHT_W-1:0] cfg_height;

  ebm_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .cfg_width  (cfg_width),
    .cfg_height (cfg_height),
    .cfg_wr     (cfg_wr)
  );

  ebm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ebm_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_wr     (cfg_wr),
    .cfg_width  (cfg_width),
    .cfg_height (cfg_height),
    .pixel      (in_chan.pixel),
    .col        (out_chan.col),
    .row        (out_chan.row),
    .mean_q8    (out_chan.mean_q8),
    .frame_end  (out_chan.frame_end)
  );
endmodule
`default_nettype wire

>>> rtl/ebm_chk.sv
// port level checker for the box mean block and its bind
`timescale 1ns / 1ps
`default_nettype none
module ebm_chk (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [ebm_pkg::COL_W-1:0]   col,
  input wire logic [ebm_pkg::ROW_W-1:0]   row,
  input wire logic [ebm_pkg::MEAN_W-1:0]  mean_q8,
  input wire logic                        frame_end,
  input wire logic                        psel,
  input wire logic                        penable,
  input wire logic                        pwrite,
  input wire logic [ebm_pkg::APB_AW-1:0]  paddr,
  input wire logic [ebm_pkg::APB_DW-1:0]  pwdata,
  input wire logic [ebm_pkg::APB_DW-1:0]  prdata
);
  import ebm_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(col) && $stable(row) && $stable(mean_q8) &&
                                $stable(frame_end))
    else $error("result payload changed while stalled");

  a_no_take_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("item taken while a result waits");

  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid && !in_ready)
    else $error("result or new item right after an accepted item");

  a_width_readback: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(psel && penable && pwrite && (paddr[2] == REG_IDX_WIDTH)) &&
    (paddr[2] == REG_IDX_WIDTH) |-> prdata == APB_DW'($past(pwdata[CFG_WIDTH_W-1:0])))
    else $error("width register does not read back the written value");
endmodule

bind edge_aware_box_mean_3x3 ebm_chk u_ebm_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .col       (out_chan.col),
  .row       (out_chan.row),
  .mean_q8   (out_chan.mean_q8),
  .frame_end (out_chan.frame_end),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata)
);
`default_nettype wire
